>>> design/qbfp_pkg.sv
// ---------------------------------------------------------------------------
// qbfp_pkg
// shared types, widths and constants of the quantizing bit field packer
// ---------------------------------------------------------------------------
package qbfp_pkg;

    // default buffer size in bytes
    localparam int BUFFER_BYTES_DEF = 64;

    // item field widths
    localparam int CMD_W  = 2;
    localparam int VAL_W  = 32;
    localparam int DEC_W  = 3;
    localparam int ADDR_W = 6;
    localparam int BIT_W  = 10;
    localparam int FW_W   = 6;
    localparam int BYTE_W = 8;

    // arithmetic widths
    localparam int FRAC_W     = 16;              // fraction bits of Q16.16
    localparam int POW_W      = 14;              // holds 10^4
    localparam int PROD_W     = VAL_W + POW_W;   // product of difference and scale
    localparam int Q_W        = PROD_W - FRAC_W; // quantized value and spread
    localparam int WID_W      = 5;               // field width, at most Q_W
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);
    localparam logic [DEC_W-1:0] MAX_DEC = 3'd4;

    // a field of up to Q_W bits at any bit offset touches this many bytes
    localparam int SPAN_BYTES = (Q_W + 7 + 7) / 8;

    // small queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ATTACH = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [VAL_W-1:0] sample_value;
        logic signed [VAL_W-1:0] lower_limit;
        logic signed [VAL_W-1:0] upper_limit;
        logic [DEC_W-1:0]        decimal_places;
        logic [ADDR_W-1:0]       byte_address;
    } in_item_t;

    typedef struct packed {
        logic [BIT_W-1:0]  start_bit;
        logic [BIT_W-1:0]  end_bit;
        logic [FW_W-1:0]   field_width;
        logic [BYTE_W-1:0] read_data;
        logic              clamped;
        logic              overflow;
    } out_item_t;

    // classified item as it waits for the back end
    typedef struct packed {
        cmd_t              cmd;
        logic [VAL_W-1:0]  diff;     // clamped value minus lower limit
        logic [VAL_W-1:0]  span;     // upper minus lower, zero when reversed
        logic [DEC_W-1:0]  dec;      // saturated decimal count
        logic              clamped;
        logic [ADDR_W-1:0] addr;
    } entry_t;

    function automatic logic [POW_W-1:0] pow_ten(input logic [DEC_W-1:0] d);
        logic [POW_W-1:0] p;
        case (d)
            3'd0:    p = 14'd1;
            3'd1:    p = 14'd10;
            3'd2:    p = 14'd100;
            3'd3:    p = 14'd1000;
            default: p = 14'd10000;
        endcase
        return p;
    endfunction

endpackage

>>> design/qbfp_front.sv
// ---------------------------------------------------------------------------
// qbfp_front
// accepts items, decodes the command, clamps the value and forms differences
// ---------------------------------------------------------------------------
module qbfp_front (
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  qbfp_pkg::in_item_t cmd_item,
    output logic               push,
    input  logic               q_ready,
    output qbfp_pkg::entry_t   push_entry
);
    import qbfp_pkg::*;

    logic [VAL_W:0] dv;   // value minus lower
    logic [VAL_W:0] dr;   // upper minus lower
    logic [VAL_W:0] dh;   // value minus upper
    logic           above;
    logic           below;

    assign cmd_ready = q_ready;
    assign push      = cmd_valid && q_ready;

    always_comb
    begin
        dv = {cmd_item.sample_value[VAL_W-1], cmd_item.sample_value}
           - {cmd_item.lower_limit[VAL_W-1], cmd_item.lower_limit};
        dr = {cmd_item.upper_limit[VAL_W-1], cmd_item.upper_limit}
           - {cmd_item.lower_limit[VAL_W-1], cmd_item.lower_limit};
        dh = {cmd_item.sample_value[VAL_W-1], cmd_item.sample_value}
           - {cmd_item.upper_limit[VAL_W-1], cmd_item.upper_limit};

        above = !dh[VAL_W] && (dh != '0);
        below = dv[VAL_W];

        push_entry.cmd     = cmd_t'(cmd_item.command);
        push_entry.clamped = above || below;
        // clamp to upper first, then to lower
        if (above)
        begin
            push_entry.diff = dr[VAL_W] ? '0 : dr[VAL_W-1:0];
        end
        else
        begin
            push_entry.diff = below ? '0 : dv[VAL_W-1:0];
        end
        push_entry.span = dr[VAL_W] ? '0 : dr[VAL_W-1:0];
        push_entry.dec  = (cmd_item.decimal_places > MAX_DEC) ? MAX_DEC
                                                              : cmd_item.decimal_places;
        push_entry.addr = cmd_item.byte_address;
    end

endmodule

>>> design/qbfp_queue.sv
// ---------------------------------------------------------------------------
// qbfp_queue
// short fifo of classified items between front and back
// ---------------------------------------------------------------------------
module qbfp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  qbfp_pkg::entry_t push_entry,
    output logic             q_ready,
    input  logic             pop,
    output logic             q_valid,
    output qbfp_pkg::entry_t q_entry
);
    import qbfp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign q_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> design/qbfp_back.sv
// ---------------------------------------------------------------------------
// qbfp_back
// quantizes, sizes and writes fields into the byte buffer, serves reads
// ---------------------------------------------------------------------------
module qbfp_back #(
    parameter int BUFFER_BYTES = qbfp_pkg::BUFFER_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  qbfp_pkg::entry_t    q_entry,
    output logic                res_valid,
    input  logic                res_ready,
    output qbfp_pkg::out_item_t res_item
);
    import qbfp_pkg::*;

    localparam int CAP_BITS = BUFFER_BYTES * 8;
    localparam int POS_W    = $clog2(CAP_BITS + 1);
    localparam int MEM_AW   = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int BIDX_W   = $clog2(BUFFER_BYTES + SPAN_BYTES + 1);
    localparam int SUM_W    = ((POS_W > WID_W) ? POS_W : WID_W) + 1;
    localparam int CMP_W    = ((POS_W > ADDR_W) ? POS_W : ADDR_W) + 1;
    localparam int CAT_W    = SPAN_BYTES * 8;
    localparam int BCNT_W   = $clog2(SPAN_BYTES + 1);
    localparam int LOW_W    = WID_W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULQ,
        S_MULS,
        S_WIDTH,
        S_PLACE,
        S_WRITE,
        S_READ,
        S_DONE
    } state_t;

    state_t            state_reg;
    entry_t            ent_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [7:0]        tail_reg;     // byte holding the position, upper bits zero
    logic [Q_W-1:0]    q_reg;
    logic [Q_W-1:0]    spread_reg;
    logic [WID_W-1:0]  w_reg;
    logic [CAT_W-1:0]  cat_reg;
    logic [BIDX_W-1:0] base_reg;
    logic [BCNT_W-1:0] nbytes_reg;
    logic [BCNT_W-1:0] k_reg;
    logic [POS_W-1:0]  start_reg;
    logic              ovf_reg;
    logic              res_valid_reg;
    out_item_t         res_item_reg;

    logic [BYTE_W-1:0] pack_mem [BUFFER_BYTES];
    logic [BYTE_W-1:0] rdata_reg;

    logic [VAL_W-1:0]  mul_a;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] q_rnd;
    logic [Q_W-1:0]    spread_m1;
    logic [WID_W-1:0]  w_calc;
    logic [Q_W:0]      fmask;
    logic [Q_W-1:0]    qm;
    logic [CAT_W-1:0]  cat;
    logic [CAT_W-1:0]  cat_sh;
    logic [CAT_W-1:0]  wr_sh;
    logic [SUM_W-1:0]  end_sum;
    logic              ovf;
    logic [POS_W-1:0]  new_pos;
    logic [LOW_W-1:0]  low_sum;
    logic [LOW_W-1:0]  low_up;
    logic [BCNT_W-1:0] nbytes;
    logic [2:0]        tail_off;
    logic [7:0]        tail_next;
    logic [BIDX_W-1:0] base;
    logic [BIDX_W-1:0] waddr_full;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [MEM_AW-1:0] mem_raddr;
    logic [CMP_W-1:0]  filled;
    logic              hit;
    out_item_t         result;

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // shared multiplier: quantize first, spread next
    always_comb
    begin
        mul_a = (state_reg == S_MULS) ? ent_reg.span : ent_reg.diff;
        prod  = PROD_W'(mul_a) * PROD_W'(pow_ten(ent_reg.dec));
        q_rnd = prod + PROD_W'(ROUND_HALF);
    end

    // least w with 2^w >= spread
    always_comb
    begin
        spread_m1 = spread_reg - 1'b1;
        w_calc    = '0;
        for (int i = 0; i < Q_W; i++)
        begin
            if (spread_m1[i])
            begin
                w_calc = WID_W'(i + 1);
            end
        end
        if (spread_reg == '0)
        begin
            w_calc = '0;
        end
    end

    // field placement against the running position
    always_comb
    begin
        fmask     = ((Q_W + 1)'(1) << w_reg) - 1'b1;
        qm        = q_reg & fmask[Q_W-1:0];
        cat       = (CAT_W'(qm) << pos_reg[2:0]) | CAT_W'(tail_reg);
        end_sum   = SUM_W'(pos_reg) + SUM_W'(w_reg);
        ovf       = (end_sum > SUM_W'(CAP_BITS));
        new_pos   = ovf ? POS_W'(CAP_BITS) : end_sum[POS_W-1:0];
        low_sum   = LOW_W'(pos_reg[2:0]) + LOW_W'(w_reg);
        low_up    = low_sum + LOW_W'(7);
        nbytes    = (w_reg == '0) ? '0 : BCNT_W'(low_up >> 3);
        tail_off  = low_sum[5:3];
        cat_sh    = cat >> {tail_off, 3'b000};
        tail_next = (new_pos[2:0] == 3'd0) ? 8'd0 : cat_sh[7:0];
        base      = BIDX_W'(pos_reg >> 3);
    end

    // byte writes, one per cycle, past-the-end bytes dropped
    always_comb
    begin
        waddr_full = base_reg + BIDX_W'(k_reg);
        wr_sh      = cat_reg >> {k_reg, 3'b000};
        mem_we     = (state_reg == S_WRITE) && (waddr_full < BIDX_W'(BUFFER_BYTES));
        mem_waddr  = MEM_AW'(waddr_full);
        mem_wdata  = wr_sh[BYTE_W-1:0];
        mem_raddr  = MEM_AW'(ent_reg.addr);
        // bytes below the rounded-up position hold written data
        filled     = (CMP_W'(pos_reg) + CMP_W'(7)) >> 3;
        hit        = (CMP_W'(ent_reg.addr) < filled);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pack_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= pack_mem[mem_raddr];
    end

    always_comb
    begin
        result = '0;
        case (ent_reg.cmd)
            CMD_ATTACH:
            begin
                result.start_bit   = BIT_W'(start_reg);
                result.end_bit     = BIT_W'(pos_reg);
                result.field_width = FW_W'(w_reg);
                result.clamped     = ent_reg.clamped;
                result.overflow    = ovf_reg;
            end
            CMD_READ:
            begin
                result.read_data = hit ? rdata_reg : '0;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ent_reg       <= '0;
            pos_reg       <= '0;
            tail_reg      <= '0;
            q_reg         <= '0;
            spread_reg    <= '0;
            w_reg         <= '0;
            cat_reg       <= '0;
            base_reg      <= '0;
            nbytes_reg    <= '0;
            k_reg         <= '0;
            start_reg     <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            res_item_reg  <= '0;
        end
        else
        begin
            // in S_DONE the result register is handled by the state arm
            if (res_valid_reg && res_ready && (state_reg != S_DONE))
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        ent_reg <= q_entry;
                        case (q_entry.cmd)
                            CMD_CLEAR:
                            begin
                                pos_reg   <= '0;
                                tail_reg  <= '0;
                                state_reg <= S_DONE;
                            end
                            CMD_ATTACH: state_reg <= S_MULQ;
                            CMD_READ:   state_reg <= S_READ;
                            default:    state_reg <= S_DONE;
                        endcase
                    end
                end
                S_MULQ:
                begin
                    q_reg     <= q_rnd[FRAC_W +: Q_W];
                    state_reg <= S_MULS;
                end
                S_MULS:
                begin
                    spread_reg <= prod[FRAC_W +: Q_W];
                    state_reg  <= S_WIDTH;
                end
                S_WIDTH:
                begin
                    w_reg     <= w_calc;
                    state_reg <= S_PLACE;
                end
                S_PLACE:
                begin
                    cat_reg    <= cat;
                    base_reg   <= base;
                    nbytes_reg <= nbytes;
                    k_reg      <= '0;
                    start_reg  <= pos_reg;
                    ovf_reg    <= ovf;
                    pos_reg    <= new_pos;
                    tail_reg   <= tail_next;
                    state_reg  <= (nbytes == '0) ? S_DONE : S_WRITE;
                end
                S_WRITE:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == nbytes_reg - 1'b1)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_READ:
                begin
                    // memory read lands at the end of this cycle
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        res_item_reg  <= result;
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/quantizing_bit_field_packer.sv
// ---------------------------------------------------------------------------
// quantizing_bit_field_packer
// telemetry packer: quantizes limited Q16.16 values and appends them as
// variable-width fields, lsb first, into a byte buffer
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ----------------------
//  cmd       in         cmd_valid / cmd_ready  cmd_item  (in_item_t)
//  res       out        res_valid / res_ready  res_item  (out_item_t)
//
//  the back end finishes one item before it takes the next; an attach
//  writes n (0 to 5) buffer bytes, those the field touches, with one
//  byte write per cycle into the buffer memory
//  an accepted item is registered in the queue and reaches the back end
//  when it is idle; reset clears position and tail byte but not the
//  buffer, which is tracked by the running position, so no clearing
//  pass is needed after reset or clear; a stalled result holds the back
//  end, the queue keeps taking items until its two slots are full
//
module quantizing_bit_field_packer #(
    parameter int BUFFER_BYTES = qbfp_pkg::BUFFER_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  qbfp_pkg::in_item_t  cmd_item,
    output logic                res_valid,
    input  logic                res_ready,
    output qbfp_pkg::out_item_t res_item
);
    import qbfp_pkg::*;

    // front to queue
    logic   push;
    logic   q_ready;
    entry_t push_entry;

    // queue to back
    logic   q_valid;
    logic   q_pop;
    entry_t q_entry;

    // decode, clamp and range differences
    qbfp_front u_front (
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_item   (cmd_item),
        .push       (push),
        .q_ready    (q_ready),
        .push_entry (push_entry)
    );

    // decouples intake from the multi-cycle back end
    qbfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .q_ready    (q_ready),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    // quantize, size, write bytes, serve reads, hold the result register
    qbfp_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_entry   (q_entry),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule

>>> design/qbfp_checker.sv
// ---------------------------------------------------------------------------
// qbfp_checker
// port-level checks on the result channel of the packer
// ---------------------------------------------------------------------------
module qbfp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_ready,
    input qbfp_pkg::out_item_t res_item
);
    import qbfp_pkg::*;

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_item))
        else $error("result changed while stalled");

    // without overflow the field ends exactly width bits after its start
    a_end_matches: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.overflow
            |-> res_item.end_bit == res_item.start_bit + res_item.field_width)
        else $error("end bit does not match start plus width");

    a_width_max: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_item.field_width <= FW_W'(Q_W))
        else $error("field width out of range");

    // read results carry nothing of an attach
    a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.read_data != '0
            |-> res_item.start_bit == '0 && res_item.end_bit == '0
                && res_item.field_width == '0 && !res_item.clamped
                && !res_item.overflow)
        else $error("read data mixed with attach fields");

    a_ovf_width: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.overflow |-> res_item.field_width != '0)
        else $error("overflow without field bits");

endmodule

bind quantizing_bit_field_packer qbfp_checker u_qbfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
);

>>> tb/packer_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// packer_checker
// tracks buffer contents and write position from every accepted item,
// predicts each result and compares it field by field with the result channel
// ---------------------------------------------------------------------------
module packer_checker #(
    parameter int BUFFER_BYTES = qbfp_pkg::BUFFER_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_ready,
    input  qbfp_pkg::in_item_t  cmd_item,
    input  logic                res_valid,
    input  logic                res_ready,
    input  qbfp_pkg::out_item_t res_item,
    output int                  failures,
    output int                  pending
);
    import qbfp_pkg::*;

    localparam int CAP_BITS = BUFFER_BYTES * 8;

    logic [7:0] packed_bytes [BUFFER_BYTES];
    int         write_pos;
    out_item_t  awaited_results [$];

    // apply one item to the buffer copy and return the result it should produce
    function automatic out_item_t pack_step(input in_item_t it);
        out_item_t        r;
        longint           val, lo, hi, v;
        bit [63:0]        scale, diff, q, spread;
        logic [DEC_W-1:0] dec;
        int               w, pos, b;
        r = '0;
        case (cmd_t'(it.command))
            CMD_CLEAR:
            begin
                foreach (packed_bytes[i])
                    packed_bytes[i] = '0;
                write_pos = 0;
            end
            CMD_ATTACH:
            begin
                val = $signed(it.sample_value);
                lo  = $signed(it.lower_limit);
                hi  = $signed(it.upper_limit);
                dec = (it.decimal_places > MAX_DEC) ? MAX_DEC : it.decimal_places;
                scale = 1;
                repeat (dec)
                    scale = scale * 10;
                r.clamped = (val < lo) || (val > hi);
                // upper bound first, then lower, so reversed limits land on lo
                v = (val > hi) ? hi : val;
                v = (v < lo) ? lo : v;
                diff = 64'(v - lo);
                q = (diff * scale + 64'(ROUND_HALF)) >> FRAC_W;
                spread = (hi > lo) ? ((64'(hi - lo) * scale) >> FRAC_W) : 64'd0;
                w = 0;
                while (w < 40 && (64'd1 << w) < spread)
                    w++;
                pos = (write_pos > CAP_BITS) ? CAP_BITS : write_pos;
                r.start_bit = BIT_W'(pos);
                for (int i = 0; i < w; i++)
                begin
                    b = pos + i;
                    if (b >= CAP_BITS)
                        r.overflow = 1'b1;
                    else
                        packed_bytes[b >> 3][b & 7] = q[i];
                end
                pos = pos + w;
                write_pos = (pos > CAP_BITS) ? CAP_BITS : pos;
                r.end_bit = BIT_W'(write_pos);
                r.field_width = FW_W'(w);
            end
            CMD_READ:
            begin
                if (it.byte_address < BUFFER_BYTES)
                    r.read_data = packed_bytes[it.byte_address];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic show(input string field, input int want, input int got);
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, field, want, got);
        failures++;
    endtask

    task automatic compare_result(input out_item_t want, input out_item_t got);
        if (got.start_bit !== want.start_bit)
            show("start_bit", int'(want.start_bit), int'(got.start_bit));
        if (got.end_bit !== want.end_bit)
            show("end_bit", int'(want.end_bit), int'(got.end_bit));
        if (got.field_width !== want.field_width)
            show("field_width", int'(want.field_width), int'(got.field_width));
        if (got.read_data !== want.read_data)
            show("read_data", int'(want.read_data), int'(got.read_data));
        if (got.clamped !== want.clamped)
            show("clamped", int'(want.clamped), int'(got.clamped));
        if (got.overflow !== want.overflow)
            show("overflow", int'(want.overflow), int'(got.overflow));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (packed_bytes[i])
                packed_bytes[i] = '0;
            write_pos = 0;
            awaited_results.delete();
            pending = 0;
        end
        else
        begin
            // results always belong to earlier items, so check before predicting
            if (res_valid && res_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual %h",
                             $time, res_item);
                    failures++;
                end
                else
                    compare_result(awaited_results.pop_front(), res_item);
            end
            if (cmd_valid && cmd_ready)
                awaited_results.push_back(pack_step(cmd_item));
            pending = awaited_results.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// drives the quantizing bit field packer with directed corner items and
// random frames of clear, attach and read items under random sender gaps and
// receiver stalls; a checker beside the block predicts and compares results
// ---------------------------------------------------------------------------
module testbench;
    import qbfp_pkg::*;

    localparam int     RANDOM_ITEMS = 1800;
    localparam int     STALL_LIMIT  = 4000;   // cycles with no item moving
    localparam int     DRAIN_CYCLES = 40;     // well past the longest attach
    localparam longint Q_MAX        = 2147483647;
    localparam longint Q_MIN        = -longint'(2147483647) - 1;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    in_item_t  cmd_item  = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    out_item_t res_item;

    int failures;
    int pending;
    int idle_cycles = 0;
    int items_sent  = 0;   // nop items are not counted
    int burst_left  = 0;

    quantizing_bit_field_packer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    packer_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .failures  (failures),
        .pending   (pending)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    // every field random, any command
    function automatic in_item_t random_fields();
        in_item_t it;
        it.command        = CMD_W'($urandom_range(0, 3));
        it.sample_value   = $urandom;
        it.lower_limit    = $urandom;
        it.upper_limit    = $urandom;
        it.decimal_places = DEC_W'($urandom_range(0, 7));
        it.byte_address   = ADDR_W'($urandom_range(0, 63));
        return it;
    endfunction

    // attach item; unused address field stays random
    function automatic in_item_t attach_of(input longint value, input longint lo,
                                           input longint hi, input int dec);
        in_item_t it;
        it                = random_fields();
        it.command        = CMD_ATTACH;
        it.sample_value   = 32'(value);
        it.lower_limit    = 32'(lo);
        it.upper_limit    = 32'(hi);
        it.decimal_places = DEC_W'(dec);
        return it;
    endfunction

    function automatic in_item_t read_of(input int addr);
        in_item_t it;
        it              = random_fields();
        it.command      = CMD_READ;
        it.byte_address = ADDR_W'(addr);
        return it;
    endfunction

    function automatic in_item_t command_of(input cmd_t op);
        in_item_t it;
        it         = random_fields();
        it.command = op;
        return it;
    endfunction

    // mostly well-formed attaches: span picked by bit count so field widths
    // spread over 0..30, value mostly inside the limits, some outside,
    // some reversed limits and some oversized decimal counts
    function automatic in_item_t shaped_attach();
        longint    lo, span, value;
        bit [63:0] wide;
        int        k, roll, dec;
        k    = $urandom_range(0, 32);
        wide = {$urandom, $urandom};
        span = (k == 0) ? 0 : longint'(wide & ((64'd1 << k) - 64'd1));
        case ($urandom_range(0, 3))
            0:       lo = Q_MIN;
            1:       lo = longint'($signed($urandom));
            default: lo = longint'($signed($urandom)) >>> $urandom_range(4, 20);
        endcase
        if (lo + span > Q_MAX)
            lo = Q_MAX - span;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            value = lo + longint'({$urandom, $urandom} % (span + 1));
        else if (roll == 6)
            value = lo;
        else if (roll == 7)
            value = lo + span;
        else
            value = longint'($signed($urandom));
        dec = ($urandom_range(0, 11) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        if ($urandom_range(0, 14) == 0)
            return attach_of(value, lo + span, lo, dec);
        return attach_of(value, lo, lo + span, dec);
    endfunction

    // present one item at the falling edge and hold it until accepted;
    // bursts of random length are followed by random gaps with valid low
    task automatic send(input in_item_t it);
        int gap;
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        do
            @(posedge clk);
        while (!cmd_ready);
        if (it.command != CMD_NOP)
            items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
            gap = $urandom_range(0, 9);
            if (gap > 0)
            begin
                @(negedge clk);
                cmd_valid <= 1'b0;
                repeat (gap - 1)
                    @(negedge clk);
            end
        end
    endtask

    // receiver: phases of always ready, coin flips, long stalls and mostly ready
    initial
    begin
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 60);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       res_ready <= 1'b1;
                    1:       res_ready <= 1'($urandom_range(0, 1));
                    2:       res_ready <= ($urandom_range(0, 5) == 0);
                    default: res_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // watchdog: no item moving on either channel for too long ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("quantizing_bit_field_packer regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int frame_len;
        int roll;
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;

        // fresh buffer reads zero
        send(read_of(0));
        // spread of one gives a zero-width field
        send(attach_of(64'h1_0000, 0, 64'h1_0000, 0));
        // 3.5 at the top of a 0..3.5 range rounds to 4, only two low bits kept
        send(attach_of(64'h3_8000, 0, 64'h3_8000, 0));
        // reversed limits: width zero, always clamped
        send(attach_of(5, 64'h1_0000, 0, 2));
        // above and below the range, clamped to each limit
        send(attach_of(100 * 65536, 0, 10 * 65536, 1));
        send(attach_of(-3 * 65536, 0, 10 * 65536, 1));
        // equal limits
        send(attach_of(7 * 65536, 7 * 65536, 7 * 65536, 3));
        // full range at four decimals, lowest value: widest field
        send(attach_of(Q_MIN, Q_MIN, Q_MAX, 4));
        // nop command does nothing
        send(command_of(CMD_NOP));

        // fill with widest fields until bits fall past the buffer end;
        // first one uses a decimal count that saturates
        send(attach_of(Q_MAX, Q_MIN, Q_MAX, 7));
        repeat (15)
            send(attach_of(longint'($signed($urandom)), Q_MIN, Q_MAX, 4));
        send(read_of(0));
        send(read_of(63));
        send(command_of(CMD_CLEAR));

        // random frames: usually a clear, then a run of attaches with a few
        // reads and nops mixed in, then reads biased toward the written bytes
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) != 0)
                send(command_of(CMD_CLEAR));
            frame_len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 45)
                                                     : $urandom_range(1, 15);
            repeat (frame_len)
            begin
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    send(command_of(CMD_NOP));
                else if (roll < 3)
                    send(read_of($urandom_range(0, 63)));
                else
                    send(shaped_attach());
            end
            repeat ($urandom_range(1, 8))
                send(read_of($urandom_range(0, $urandom_range(0, 63))));
        end

        @(negedge clk);
        cmd_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("quantizing_bit_field_packer regression: pass");
        else
            $display("quantizing_bit_field_packer regression: fail");
        $finish;
    end

endmodule
